### rtl/sept_pkg.sv
// sept_pkg: shared types, widths and codes for the sorted envelope point table
// used by sept_front, sept_back and sorted_envelope_point_table
package sept_pkg;

   // table geometry
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int MRK_W      = IDX_W + 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // default payload widths
   localparam int DEF_TIME_BITS  = 16;
   localparam int DEF_VALUE_BITS = 16;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // marker slots
   localparam int NUM_MARKERS      = 4;
   localparam int MK_SUSTAIN_BEGIN = 0;
   localparam int MK_SUSTAIN_END   = 1;
   localparam int MK_LOOP_START    = 2;
   localparam int MK_LOOP_END      = 3;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SET    = 2'd2,
      OP_MARKER = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
      logic [1:0]       sel;
      logic [MRK_W-1:0] marker;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_INS,
      B_DEL,
      B_SDN,
      B_SUP,
      B_PUT,
      B_DROP
   } back_state_type;

endpackage

### rtl/sept_ram.sv
// sept_ram: generic single write port, single read port ram with registered read
// no dependencies
module sept_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/sept_front.sv
// sept_front: accepts command transactions, classifies them and queues them
// depends on sept_pkg
module sept_front #(
   parameter int TIME_BITS  = sept_pkg::DEF_TIME_BITS,
   parameter int VALUE_BITS = sept_pkg::DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic [sept_pkg::IDX_W-1:0]   req_point_index,
   input  logic [TIME_BITS-1:0]         req_point_time,
   input  logic [VALUE_BITS-1:0]        req_point_value,
   input  logic [1:0]                   req_marker_select,
   input  logic [sept_pkg::MRK_W-1:0]   req_marker_value,
   input  logic                         take,
   output logic                         head_valid,
   output sept_pkg::cmd_type            head_cmd,
   output logic [TIME_BITS-1:0]         head_time,
   output logic [VALUE_BITS-1:0]        head_value
);

   sept_pkg::cmd_type                 q_cmd_ff   [sept_pkg::QUEUE_DEPTH];
   logic [TIME_BITS-1:0]              q_time_ff  [sept_pkg::QUEUE_DEPTH];
   logic [VALUE_BITS-1:0]             q_value_ff [sept_pkg::QUEUE_DEPTH];
   logic [sept_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sept_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sept_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              push;
   logic                              pop;
   logic                              mk_bad;
   sept_pkg::cmd_type                 cls_cmd;

   // classify: saturate out-of-table marker values to invalid
   always_comb begin
      mk_bad = req_marker_value[sept_pkg::MRK_W-1] ||
               (sept_pkg::CNT_W'(req_marker_value[sept_pkg::IDX_W-1:0]) >=
                sept_pkg::CNT_W'(sept_pkg::MAX_POINTS));
      cls_cmd.op     = sept_pkg::op_type'(req_action);
      cls_cmd.idx    = req_point_index;
      cls_cmd.sel    = req_marker_select;
      cls_cmd.marker = mk_bad ? '1 : req_marker_value;
   end

   assign busy       = (fill_ff == sept_pkg::QCNT_W'(sept_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign push       = start && !busy;
   assign pop        = take && head_valid;
   assign head_cmd   = q_cmd_ff[rd_ptr_ff];
   assign head_time  = q_time_ff[rd_ptr_ff];
   assign head_value = q_value_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sept_pkg::QPTR_W'(sept_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sept_pkg::QPTR_W'(sept_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff]   <= cls_cmd;
         q_time_ff[wr_ptr_ff]  <= req_point_time;
         q_value_ff[wr_ptr_ff] <= req_point_value;
      end
   end

endmodule

### rtl/sept_back.sv
// sept_back: executes queued commands against the point ram and the markers
// depends on sept_pkg and sept_ram
module sept_back #(
   parameter int TIME_BITS  = sept_pkg::DEF_TIME_BITS,
   parameter int VALUE_BITS = sept_pkg::DEF_VALUE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  sept_pkg::cmd_type           head_cmd,
   input  logic [TIME_BITS-1:0]        head_time,
   input  logic [VALUE_BITS-1:0]       head_value,
   output logic                        take,
   output logic                        rsp_strobe,
   output logic [sept_pkg::MRK_W-1:0]  rsp_result_index,
   output logic [1:0]                  rsp_status,
   output logic [sept_pkg::CNT_W-1:0]  rsp_point_count,
   output logic [sept_pkg::MRK_W-1:0]  rsp_markers [sept_pkg::NUM_MARKERS]
);

   localparam int IDX_W = sept_pkg::IDX_W;
   localparam int MRK_W = sept_pkg::MRK_W;
   localparam int CNT_W = sept_pkg::CNT_W;
   localparam int WORD_W = TIME_BITS + VALUE_BITS;

   sept_pkg::back_state_type state_ff, state_in;

   sept_pkg::op_type        op_ff, op_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [IDX_W-1:0]        dst_ff, dst_in;
   logic                    first_ff, first_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MRK_W-1:0]        marker_ff [sept_pkg::NUM_MARKERS];
   logic [MRK_W-1:0]        marker_in [sept_pkg::NUM_MARKERS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MRK_W-1:0]        rsp_idx_ff, rsp_idx_in;
   sept_pkg::status_type    rsp_status_ff, rsp_status_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [WORD_W-1:0]       ram_wdata;
   logic [IDX_W-1:0]        ram_raddr;
   logic [WORD_W-1:0]       ram_rdata;
   logic [TIME_BITS-1:0]    rd_time;

   // shared decisions
   logic [CNT_W-1:0]        cnt_m1;
   logic                    ptr_last;
   logic                    ptr_zero;
   logic                    ins_shift;
   logic                    sdn_shift;
   logic                    sup_shift;
   logic                    head_in_range;
   logic                    head_last;
   logic                    cur_last;
   logic                    table_full;
   logic                    table_empty;

   sept_ram #(
      .WIDTH (WORD_W),
      .DEPTH (sept_pkg::MAX_POINTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_time       = ram_rdata[WORD_W-1:VALUE_BITS];
   assign cnt_m1        = count_ff - 1'b1;
   assign ptr_last      = (CNT_W'(ptr_ff) == cnt_m1);
   assign ptr_zero      = (ptr_ff == '0);
   assign ins_shift     = (rd_time > time_ff);
   assign sdn_shift     = first_ff ? (rd_time > time_ff) : (rd_time >= time_ff);
   assign sup_shift     = first_ff ? (rd_time < time_ff) : (rd_time <= time_ff);
   assign head_in_range = (CNT_W'(head_cmd.idx) < count_ff);
   assign head_last     = (CNT_W'(head_cmd.idx) == cnt_m1);
   assign cur_last      = (CNT_W'(idx_ff) == cnt_m1);
   assign table_full    = (count_ff == CNT_W'(sept_pkg::MAX_POINTS));
   assign table_empty   = (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sept_pkg::B_IDLE: begin
            if (head_valid) begin
               case (head_cmd.op)
                  sept_pkg::OP_INSERT: begin
                     if (table_full) state_in = sept_pkg::B_IDLE;
                     else if (table_empty) state_in = sept_pkg::B_PUT;
                     else state_in = sept_pkg::B_INS;
                  end
                  sept_pkg::OP_DELETE: begin
                     if (!head_in_range) state_in = sept_pkg::B_IDLE;
                     else if (head_last) state_in = sept_pkg::B_DROP;
                     else state_in = sept_pkg::B_DEL;
                  end
                  sept_pkg::OP_SET: begin
                     if (!head_in_range) state_in = sept_pkg::B_IDLE;
                     else if (head_cmd.idx != '0) state_in = sept_pkg::B_SDN;
                     else if (!head_last) state_in = sept_pkg::B_SUP;
                     else state_in = sept_pkg::B_PUT;
                  end
                  default: state_in = sept_pkg::B_IDLE;
               endcase
            end
         end
         sept_pkg::B_INS: begin
            if (!ins_shift || ptr_zero) state_in = sept_pkg::B_PUT;
         end
         sept_pkg::B_DEL: begin
            if (ptr_last) state_in = sept_pkg::B_DROP;
         end
         sept_pkg::B_SDN: begin
            if (sdn_shift) begin
               if (ptr_zero) state_in = sept_pkg::B_PUT;
            end else if (first_ff && !cur_last) begin
               state_in = sept_pkg::B_SUP;
            end else begin
               state_in = sept_pkg::B_PUT;
            end
         end
         sept_pkg::B_SUP: begin
            if (!sup_shift || ptr_last) state_in = sept_pkg::B_PUT;
         end
         sept_pkg::B_PUT:  state_in = sept_pkg::B_IDLE;
         sept_pkg::B_DROP: state_in = sept_pkg::B_IDLE;
         default:          state_in = sept_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      take          = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = ptr_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      value_in      = value_ff;
      ptr_in        = ptr_ff;
      dst_in        = dst_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      marker_in     = marker_ff;
      rsp_valid_in  = 1'b0;
      rsp_idx_in    = '1;
      rsp_status_in = sept_pkg::ST_OK;

      case (state_ff)
         sept_pkg::B_IDLE: begin
            if (head_valid) begin
               take     = 1'b1;
               op_in    = head_cmd.op;
               idx_in   = head_cmd.idx;
               time_in  = head_time;
               value_in = head_value;
               case (head_cmd.op)
                  sept_pkg::OP_INSERT: begin
                     if (table_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sept_pkg::ST_FULL;
                     end else if (table_empty) begin
                        dst_in = '0;
                     end else begin
                        ptr_in    = IDX_W'(cnt_m1);
                        ram_raddr = IDX_W'(cnt_m1);
                     end
                  end
                  sept_pkg::OP_DELETE: begin
                     if (!head_in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sept_pkg::ST_RANGE;
                     end else if (!head_last) begin
                        ptr_in    = head_cmd.idx + 1'b1;
                        ram_raddr = head_cmd.idx + 1'b1;
                     end
                  end
                  sept_pkg::OP_SET: begin
                     first_in = 1'b1;
                     if (!head_in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sept_pkg::ST_RANGE;
                     end else if (head_cmd.idx != '0) begin
                        ptr_in    = head_cmd.idx - 1'b1;
                        ram_raddr = head_cmd.idx - 1'b1;
                     end else if (!head_last) begin
                        ptr_in    = head_cmd.idx + 1'b1;
                        ram_raddr = head_cmd.idx + 1'b1;
                     end else begin
                        dst_in = head_cmd.idx;
                     end
                  end
                  default: begin
                     marker_in[head_cmd.sel] = head_cmd.marker;
                     rsp_valid_in            = 1'b1;
                  end
               endcase
            end
         end

         // walk down from the last point, moving later times up one slot
         sept_pkg::B_INS: begin
            if (ins_shift) begin
               ram_we    = 1'b1;
               ram_waddr = ptr_ff + 1'b1;
               if (ptr_zero) begin
                  dst_in = '0;
               end else begin
                  ptr_in    = ptr_ff - 1'b1;
                  ram_raddr = ptr_ff - 1'b1;
               end
            end else begin
               dst_in = ptr_ff + 1'b1;
            end
         end

         // close the gap: each later point moves down one slot
         sept_pkg::B_DEL: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff - 1'b1;
            if (!ptr_last) begin
               ptr_in    = ptr_ff + 1'b1;
               ram_raddr = ptr_ff + 1'b1;
            end
         end

         // moved point lands earlier: push later times up, equal ones too past the first neighbour
         sept_pkg::B_SDN: begin
            if (sdn_shift) begin
               ram_we    = 1'b1;
               ram_waddr = ptr_ff + 1'b1;
               if (ptr_zero) begin
                  dst_in = '0;
               end else begin
                  ptr_in    = ptr_ff - 1'b1;
                  ram_raddr = ptr_ff - 1'b1;
                  first_in  = 1'b0;
               end
            end else if (first_ff && !cur_last) begin
               ptr_in    = idx_ff + 1'b1;
               ram_raddr = idx_ff + 1'b1;
               first_in  = 1'b1;
            end else begin
               dst_in = ptr_ff + 1'b1;
            end
         end

         // moved point lands later: pull earlier times down, equal ones too past the first neighbour
         sept_pkg::B_SUP: begin
            if (sup_shift) begin
               ram_we    = 1'b1;
               ram_waddr = ptr_ff - 1'b1;
               if (ptr_last) begin
                  dst_in = ptr_ff;
               end else begin
                  ptr_in    = ptr_ff + 1'b1;
                  ram_raddr = ptr_ff + 1'b1;
                  first_in  = 1'b0;
               end
            end else begin
               dst_in = ptr_ff - 1'b1;
            end
         end

         sept_pkg::B_PUT: begin
            ram_we       = 1'b1;
            ram_waddr    = dst_ff;
            ram_wdata    = {time_ff, value_ff};
            rsp_valid_in = 1'b1;
            rsp_idx_in   = MRK_W'(dst_ff);
            if (op_ff == sept_pkg::OP_INSERT) begin
               count_in = count_ff + 1'b1;
               // markers move only when the point does not go at the end
               if (CNT_W'(dst_ff) < count_ff) begin
                  for (int m = 0; m < sept_pkg::NUM_MARKERS; m++) begin
                     if (!marker_ff[m][MRK_W-1] &&
                         (marker_ff[m][IDX_W-1:0] >= dst_ff)) begin
                        if (marker_ff[m][IDX_W-1:0] ==
                            IDX_W'(sept_pkg::MAX_POINTS - 1)) begin
                           marker_in[m] = '1;
                        end else begin
                           marker_in[m] = marker_ff[m] + 1'b1;
                        end
                     end
                  end
               end
            end else begin
               for (int m = 0; m < sept_pkg::NUM_MARKERS; m++) begin
                  if (!marker_ff[m][MRK_W-1]) begin
                     if ((dst_ff > idx_ff) &&
                         (marker_ff[m][IDX_W-1:0] > idx_ff) &&
                         (marker_ff[m][IDX_W-1:0] <= dst_ff)) begin
                        marker_in[m] = marker_ff[m] - 1'b1;
                     end else if ((dst_ff < idx_ff) &&
                                  (marker_ff[m][IDX_W-1:0] < idx_ff) &&
                                  (marker_ff[m][IDX_W-1:0] >= dst_ff)) begin
                        marker_in[m] = marker_ff[m] + 1'b1;
                     end
                  end
               end
            end
         end

         // removing a pair member kills the pair, else later markers step down
         sept_pkg::B_DROP: begin
            rsp_valid_in = 1'b1;
            count_in     = count_ff - 1'b1;
            for (int p = 0; p < sept_pkg::NUM_MARKERS; p += 2) begin
               if ((marker_ff[p] == MRK_W'(idx_ff)) ||
                   (marker_ff[p+1] == MRK_W'(idx_ff))) begin
                  marker_in[p]   = '1;
                  marker_in[p+1] = '1;
               end else begin
                  for (int q = p; q < p + 2; q++) begin
                     if (!marker_ff[q][MRK_W-1] &&
                         (marker_ff[q][IDX_W-1:0] > idx_ff)) begin
                        marker_in[q] = marker_ff[q] - 1'b1;
                     end
                  end
               end
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sept_pkg::B_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= sept_pkg::ST_OK;
         for (int m = 0; m < sept_pkg::NUM_MARKERS; m++) begin
            marker_ff[m] <= '1;
         end
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         marker_ff     <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      time_ff    <= time_in;
      value_ff   <= value_in;
      ptr_ff     <= ptr_in;
      dst_ff     <= dst_in;
      first_ff   <= first_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_point_count  = count_ff;
   assign rsp_markers      = marker_ff;

   // a returned slot always points into the table
   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_idx_ff[MRK_W-1]) |->
         (CNT_W'(rsp_idx_ff[IDX_W-1:0]) < count_ff))
      else $error("returned slot lies beyond point count");

   // the point count only moves together with a result
   a_count_with_result: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> rsp_valid_ff)
      else $error("point count changed without a result");

   // the walk pointer of a ram walk never points past the table
   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sept_pkg::B_INS || state_ff == sept_pkg::B_DEL ||
       state_ff == sept_pkg::B_SDN || state_ff == sept_pkg::B_SUP) |->
         (CNT_W'(ptr_ff) < count_ff))
      else $error("walk pointer beyond point count");

   // a full report only comes from a full table
   a_full_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == sept_pkg::ST_FULL) |->
         (count_ff == CNT_W'(sept_pkg::MAX_POINTS)))
      else $error("table full reported while not full");

endmodule

### rtl/sorted_envelope_point_table.sv
// sorted_envelope_point_table: top level of the sorted envelope point table
// depends on sept_pkg, sept_front, sept_back (and sept_ram below it)
//
// usage
//   command channel: a transaction is taken at a rising edge with start high and
//   busy low; req_action selects insert, delete, set point or set marker
//   result channel: rsp_strobe is high for one cycle per command and carries the
//   new slot, a status code, the point count and the four markers after the
//   command; the receiver cannot hold results off, results leave in order
//   commands land in a two-entry queue, so busy only rises when that queue is
//   full while the back end still works on an earlier command
// walks over the point ram per command
//   set marker, out of range or table full: no walk over the point ram
//   insert: a walk down from the last point over the points that move up
//   (no walk into an empty table)
//   delete: a walk over the points that move down
//   set point: a walk over the points passed by the moved point, plus a compare
//   that ends the walk short of the table ends; it may first look below and
//   then look above
//   the back end takes the next queued command while a result is on the ports
//   each walk steps one slot per cycle through the single read port and single
//   write port of the point ram
// reset
//   synchronous, active high: empties the table and the queue and marks all
//   markers invalid; the point ram itself is not cleared
module sorted_envelope_point_table #(
   parameter int TIME_BITS  = sept_pkg::DEF_TIME_BITS,
   parameter int VALUE_BITS = sept_pkg::DEF_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [sept_pkg::IDX_W-1:0]         req_point_index,
   input  logic [TIME_BITS-1:0]               req_point_time,
   input  logic [VALUE_BITS-1:0]              req_point_value,
   input  logic [1:0]                         req_marker_select,
   input  logic signed [sept_pkg::MRK_W-1:0]  req_marker_value,
   // result channel
   output logic                               rsp_strobe,
   output logic signed [sept_pkg::MRK_W-1:0]  rsp_result_index,
   output logic [1:0]                         rsp_status,
   output logic [sept_pkg::CNT_W-1:0]         rsp_point_count,
   output logic signed [sept_pkg::MRK_W-1:0]  rsp_sustain_begin_out,
   output logic signed [sept_pkg::MRK_W-1:0]  rsp_sustain_end_out,
   output logic signed [sept_pkg::MRK_W-1:0]  rsp_loop_start_out,
   output logic signed [sept_pkg::MRK_W-1:0]  rsp_loop_end_out
);

   // queue head, from front to back
   logic                          head_valid;
   sept_pkg::cmd_type             head_cmd;
   logic [TIME_BITS-1:0]          head_time;
   logic [VALUE_BITS-1:0]         head_value;
   logic                          take;

   // marker registers as seen by the result channel
   logic [sept_pkg::MRK_W-1:0]    markers [sept_pkg::NUM_MARKERS];

   // front: accept, classify (marker saturation) and queue
   sept_front #(
      .TIME_BITS  (TIME_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_point_index   (req_point_index),
      .req_point_time    (req_point_time),
      .req_point_value   (req_point_value),
      .req_marker_select (req_marker_select),
      .req_marker_value  (req_marker_value),
      .take              (take),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .head_time         (head_time),
      .head_value        (head_value)
   );

   // back: point ram walks, marker updates and result register
   sept_back #(
      .TIME_BITS  (TIME_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .head_time        (head_time),
      .head_value       (head_value),
      .take             (take),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status),
      .rsp_point_count  (rsp_point_count),
      .rsp_markers      (markers)
   );

   // marker slots onto their named ports
   assign rsp_sustain_begin_out = markers[sept_pkg::MK_SUSTAIN_BEGIN];
   assign rsp_sustain_end_out   = markers[sept_pkg::MK_SUSTAIN_END];
   assign rsp_loop_start_out    = markers[sept_pkg::MK_LOOP_START];
   assign rsp_loop_end_out      = markers[sept_pkg::MK_LOOP_END];

endmodule
